[src/cgtd_pkg.sv]
// Shared types and constants for the credit-gated tail-drop buffer.
// No dependencies; every other file of the block but cgtd_skid imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cgtd_pkg;

	localparam int QUEUE_DEPTH_DEF  = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int REQ_W   = 2;
	localparam int ACT_W   = 2;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_ARRIVE = 2'd0,
		REQ_ACK    = 2'd1,
		REQ_TICK   = 2'd2
	} cgtd_req_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE = 2'd0,
		ACT_FWD  = 2'd1,
		ACT_DROP = 2'd2
	} cgtd_act_t;

	// per-cell control: shift pulls the neighbor's entry, load takes the write data
	typedef struct packed {
		logic shift;
		logic load;
	} cgtd_cell_ctrl_t;

	// queue command for the whole cell row
	typedef struct packed {
		logic pop;
		logic push;
	} cgtd_chain_cmd_t;

endpackage

`default_nettype wire

[src/cgtd_req_if.sv]
// Request channel of the credit-gated tail-drop buffer: event type and payload.
// Depends on cgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cgtd_req_if #(
	parameter int PAYLOAD_BITS = 32
);
	import cgtd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, output req_type, output payload, input ready);
	modport sink   (input valid, input req_type, input payload, output ready);

endinterface

`default_nettype wire

[src/cgtd_res_if.sv]
// Result channel of the credit-gated tail-drop buffer: action, payload, queue length.
// Depends on cgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cgtd_res_if #(
	parameter int PAYLOAD_BITS = 32,
	parameter int LEN_W        = 7
);
	import cgtd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [LEN_W-1:0]        queue_length;

	modport source (output valid, output action, output out_payload, output queue_length,
		input ready);
	modport sink   (input valid, input action, input out_payload, input queue_length,
		output ready);

endinterface

`default_nettype wire

[src/cgtd_cfg_if.sv]
// Configuration write channel: carries the queue limit register value.
// Depends on cgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cgtd_cfg_if;
	import cgtd_pkg::*;

	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] queue_limit;

	modport source (output valid, output queue_limit, input ready);
	modport sink   (input valid, input queue_limit, output ready);

endinterface

`default_nettype wire

[src/cgtd_cell.sv]
// One queue cell: holds a single entry, loads new data or takes its neighbor's entry.
// Depends on cgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgtd_cell #(
	parameter int PAYLOAD_BITS = cgtd_pkg::PAYLOAD_BITS_DEF
) (
	input  wire                          clk,
	input  cgtd_pkg::cgtd_cell_ctrl_t    ctrl,
	input  wire  [PAYLOAD_BITS-1:0]      load_data,
	input  wire  [PAYLOAD_BITS-1:0]      next_data,
	output logic [PAYLOAD_BITS-1:0]      data
);
	import cgtd_pkg::*;

	logic [PAYLOAD_BITS-1:0] data_q;

	// load wins: on a rotation the tail cell takes the requeued entry
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

[src/cgtd_cell_chain.sv]
// Row of queue cells; cell 0 is the head, entries move one cell toward it on a pop.
// Depends on cgtd_pkg and cgtd_cell.
`timescale 1ns / 1ps
`default_nettype none

module cgtd_cell_chain #(
	parameter int QUEUE_DEPTH  = cgtd_pkg::QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS = cgtd_pkg::PAYLOAD_BITS_DEF,
	localparam int IdxW        = $clog2(QUEUE_DEPTH)
) (
	input  wire                          clk,
	input  cgtd_pkg::cgtd_chain_cmd_t    cmd,
	input  wire  [IdxW-1:0]              wr_pos,
	input  wire  [PAYLOAD_BITS-1:0]      wr_data,
	output logic [PAYLOAD_BITS-1:0]      head
);
	import cgtd_pkg::*;

	logic [PAYLOAD_BITS-1:0] cell_data [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cgtd_cell_ctrl_t         ctrl;
		logic [PAYLOAD_BITS-1:0] next_data;

		assign ctrl.shift = cmd.pop;
		assign ctrl.load  = cmd.push && (wr_pos == IdxW'(i));

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i + 1];
		end

		cgtd_cell #(
			.PAYLOAD_BITS(PAYLOAD_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_data(wr_data),
			.next_data(next_data),
			.data     (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

`default_nettype wire

[src/cgtd_skid.sv]
// Two-entry output stage: result register plus skid register, so input ready is
// registered and one more beat is taken while the receiver stalls. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cgtd_skid #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	input  wire  [W-1:0] in_data,
	output logic         in_ready,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic         skid_valid_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] skid_data_q;
	logic         advance;

	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end else if (in_valid) begin
			skid_data_q <= in_data;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[src/credit_gated_tail_drop_buffer.sv]
// Credit-gated tail-drop packet buffer, top level.
// Depends on cgtd_pkg, the cgtd_*_if interfaces, cgtd_cell_chain and cgtd_skid.
//
// Usage:
//   req  : one beat per event (arrival, consumer ack, service tick) with payload.
//   res  : exactly one beat per req beat, in order: action (none, forward, drop),
//          the forwarded or dropped payload (zero otherwise) and the queue length
//          after the event.
//   cfg  : writes the queue limit; always ready, to be written only while idle.
// The result beat is registered in the output stage when its req beat is taken.
// Throughput: one event per cycle while req.ready is high. All state is updated
// as the event is taken; the queue is a row of QUEUE_DEPTH cells that shift toward
// the head on a pop, head always in cell 0, so pop, push and requeue are one move.
// Receiver stall: the output stage holds two results; req.ready drops once the
// second one is parked and rises again the cycle after the receiver takes one.
// Reset: queue empty, nothing under service, credit present, limit 16. Queue
// cells are not cleared; an entry is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module credit_gated_tail_drop_buffer #(
	parameter int QUEUE_DEPTH  = cgtd_pkg::QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS = cgtd_pkg::PAYLOAD_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	cgtd_cfg_if.sink   cfg,
	cgtd_req_if.sink   req,
	cgtd_res_if.source res
);
	import cgtd_pkg::*;

	localparam int IdxW  = $clog2(QUEUE_DEPTH);
	localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CmpW  = (CntW > LIMIT_W) ? CntW : LIMIT_W;
	localparam int ResW  = ACT_W + PAYLOAD_BITS + CntW;

	logic [LIMIT_W-1:0]      limit_q;
	logic                    busy_q;
	logic                    credit_q;
	logic [CntW-1:0]         fill_q;
	logic [PAYLOAD_BITS-1:0] held_q;

	logic                    busy_d;
	logic                    credit_d;
	logic [CntW-1:0]         fill_d;
	logic [PAYLOAD_BITS-1:0] held_d;

	logic                    fire;
	logic                    in_ready;
	logic [CmpW-1:0]         limit_eff;
	logic [PAYLOAD_BITS-1:0] head;
	cgtd_chain_cmd_t         cmd;
	logic [IdxW-1:0]         wr_pos;
	logic [PAYLOAD_BITS-1:0] wr_data;
	cgtd_act_t               act;
	logic [PAYLOAD_BITS-1:0] act_pay;
	logic [ResW-1:0]         res_data;

	assign fire      = req.valid && in_ready;
	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	assign limit_eff = (CmpW'(limit_q) > CmpW'(QUEUE_DEPTH)) ? CmpW'(QUEUE_DEPTH)
		: CmpW'(limit_q);

	always_comb begin
		logic                    do_svc;
		logic [PAYLOAD_BITS-1:0] cur_held;

		do_svc   = 1'b0;
		cur_held = held_q;
		busy_d   = busy_q;
		credit_d = credit_q;
		fill_d   = fill_q;
		held_d   = held_q;
		cmd      = '0;
		wr_pos   = IdxW'(fill_q);
		wr_data  = req.payload;
		act      = ACT_NONE;
		act_pay  = '0;

		if (fire) begin
			unique case (req.req_type)
				REQ_ARRIVE: begin
					if (!busy_q) begin
						// idle: take it under service and serve it right away
						do_svc   = 1'b1;
						cur_held = req.payload;
						busy_d   = 1'b1;
						held_d   = req.payload;
					end else if (CmpW'(fill_q) < limit_eff) begin
						cmd.push = 1'b1;
						fill_d   = fill_q + CntW'(1);
					end else begin
						act     = ACT_DROP;
						act_pay = req.payload;
					end
				end
				REQ_ACK: begin
					credit_d = 1'b1;
				end
				REQ_TICK: begin
					do_svc = busy_q;
				end
				default: begin
				end
			endcase
		end

		if (do_svc) begin
			if (credit_q) begin
				act      = ACT_FWD;
				act_pay  = cur_held;
				credit_d = 1'b0;
				if (fill_q == '0) begin
					busy_d = 1'b0;
					held_d = '0;
				end else begin
					held_d  = head;
					cmd.pop = 1'b1;
					fill_d  = fill_q - CntW'(1);
				end
			end else if (fill_q != '0) begin
				// no credit: rotate, held entry goes to the tail, head comes out
				held_d   = head;
				cmd.pop  = 1'b1;
				cmd.push = 1'b1;
				wr_pos   = IdxW'(fill_q - CntW'(1));
				wr_data  = cur_held;
			end else begin
				held_d = cur_held;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			busy_q   <= 1'b0;
			credit_q <= 1'b1;
			fill_q   <= '0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.queue_limit;
			end
			busy_q   <= busy_d;
			credit_q <= credit_d;
			fill_q   <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

	cgtd_cell_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_chain (
		.clk    (clk),
		.cmd    (cmd),
		.wr_pos (wr_pos),
		.wr_data(wr_data),
		.head   (head)
	);

	cgtd_skid #(
		.W(ResW)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fire),
		.in_data  ({act, act_pay, fill_d}),
		.in_ready (in_ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.out_data (res_data)
	);

	assign res.action       = res_data[ResW-1 -: ACT_W];
	assign res.out_payload  = res_data[CntW +: PAYLOAD_BITS];
	assign res.queue_length = res_data[CntW-1:0];

`ifndef SYNTH
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> fill_q == '0)
		else $error("queue holds entries while nothing is under service");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(QUEUE_DEPTH))
		else $error("queue fill beyond cell count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res.valid)
		else $error("accepted beat produced no result");

	a_ack_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.req_type == REQ_ACK |=> credit_q)
		else $error("acknowledgement did not restore credit");
`endif

endmodule

`default_nettype wire
